// ----- hw/rtl/lobci_pkg.sv -----
// Package for the linear octree box cell index block.
// Widths, register indexes, the Morton bit spreader and the level base table.
// No dependencies.
`timescale 1ns / 1ps

package lobci_pkg;

   localparam int MAX_LEVELS = 7;
   localparam int CELL_W     = MAX_LEVELS;
   localparam int CODE_W     = 3 * MAX_LEVELS;
   localparam int LEVEL_W    = 3;
   localparam int INDEX_W    = 22;
   localparam int COORD_W    = 32;
   localparam int HALF_W     = 31;
   localparam int INV_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DIV_LEVEL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_SIZE_X = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_SIZE_Y = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_SIZE_Z = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL_X  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL_Y  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_CELL_Z  = 3'd6;

   // bit i of the cell goes to bit 3i of the code
   function automatic logic [CODE_W-1:0] spread3(input logic [CELL_W-1:0] v);
      logic [CODE_W-1:0] s;
      s = '0;
      for (int i = 0; i < CELL_W; i++) begin
         s[3*i] = v[i];
      end
      return s;
   endfunction

   // (8^lvl - 1) / 7, index of the first cell at that level
   function automatic logic [INDEX_W-1:0] level_base(input logic [LEVEL_W-1:0] lvl);
      logic [INDEX_W-1:0] b;
      case (lvl)
         3'd0: b = 22'd0;
         3'd1: b = 22'd1;
         3'd2: b = 22'd9;
         3'd3: b = 22'd73;
         3'd4: b = 22'd585;
         3'd5: b = 22'd4681;
         3'd6: b = 22'd37449;
         3'd7: b = 22'd299593;
         default: b = 22'd0;
      endcase
      return b;
   endfunction

endpackage

// ----- hw/rtl/lobci_if.sv -----
// Channel interfaces: box request words in, cell index response words out.
// Depends on lobci_pkg for field widths.
`timescale 1ns / 1ps

interface lobci_req_if
   import lobci_pkg::*;
   ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] min_x;
   logic signed [COORD_W-1:0] min_y;
   logic signed [COORD_W-1:0] min_z;
   logic signed [COORD_W-1:0] max_x;
   logic signed [COORD_W-1:0] max_y;
   logic signed [COORD_W-1:0] max_z;

   modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z, input ready);
   modport sink   (input valid, min_x, min_y, min_z, max_x, max_y, max_z, output ready);
endinterface

interface lobci_rsp_if
   import lobci_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] cell_index;
   logic [LEVEL_W-1:0] cell_level;
   logic               out_of_area;

   modport source (output valid, cell_index, cell_level, out_of_area, input ready);
   modport sink   (input valid, cell_index, cell_level, out_of_area, output ready);
endinterface

// ----- hw/rtl/linear_octree_box_cell_index.sv -----
// Linear octree cell index of an axis-aligned box, Q16.16 corners in.
// Depends on lobci_pkg and the channel interfaces in lobci_if.sv.
//
//   channel   dir  handshake          word
//   req_bus   in   valid/ready        min_x..max_z, signed Q16.16
//   rsp_bus   out  valid/ready        cell_index, cell_level, out_of_area
//   csr_*     in   csr_we             csr_index selects, csr_wdata
//
// One word per cycle while the output is not stalled; stages: input register,
// offset/magnitude, 32x32 cell multiply, clamp/interleave/level to the output register.
// The four stages advance together; the pipe holds while the output word waits.
// Reset (synchronous) empties the pipe and clears the configuration registers to zero.
`timescale 1ns / 1ps

module linear_octree_box_cell_index
   import lobci_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   lobci_req_if.sink             req_bus,
   lobci_rsp_if.source           rsp_bus,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef logic signed [COORD_W-1:0] coord_type;

   logic [LEVEL_W-1:0] div_level_ff;
   logic [HALF_W-1:0]  half_ff [3];
   logic [INV_W-1:0]   inv_ff  [3];

   logic      adv;
   logic      v1_ff, v2_ff, v3_ff, vo_ff;
   coord_type coord_ff [6];
   logic [31:0] mag_ff [6];
   logic [31:0] mag_in [6];
   logic        neg2_ff [6];
   logic        neg2_in [6];
   logic [31:0] ipart_ff [6];
   logic [31:0] ipart_in [6];
   logic        neg3_ff [6];

   logic [INDEX_W-1:0] index_ff, index_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               flag_ff, flag_in;

   // ---------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         div_level_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            half_ff[a] <= '0;
            inv_ff[a]  <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_DIV_LEVEL: begin
               if (32'(csr_wdata[LEVEL_W-1:0]) <= 32'(MAX_LEVELS)) begin
                  div_level_ff <= csr_wdata[LEVEL_W-1:0];
               end
            end
            CSR_HALF_SIZE_X: half_ff[0] <= csr_wdata[HALF_W-1:0];
            CSR_HALF_SIZE_Y: half_ff[1] <= csr_wdata[HALF_W-1:0];
            CSR_HALF_SIZE_Z: half_ff[2] <= csr_wdata[HALF_W-1:0];
            CSR_INV_CELL_X:  inv_ff[0]  <= csr_wdata[INV_W-1:0];
            CSR_INV_CELL_Y:  inv_ff[1]  <= csr_wdata[INV_W-1:0];
            CSR_INV_CELL_Z:  inv_ff[2]  <= csr_wdata[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipe control
   assign adv           = !vo_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_bus.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         vo_ff <= v3_ff;
      end
   end

   // ---------------- stage 1: input register
   always_ff @(posedge clock) begin
      if (adv) begin
         coord_ff[0] <= req_bus.min_x;
         coord_ff[1] <= req_bus.min_y;
         coord_ff[2] <= req_bus.min_z;
         coord_ff[3] <= req_bus.max_x;
         coord_ff[4] <= req_bus.max_y;
         coord_ff[5] <= req_bus.max_z;
      end
   end

   // ---------------- stage 2: offset by half size, sign and magnitude
   // |t| fits 32 bits: t lies in [-2^31, 2^32 - 2]
   always_comb begin
      logic [COORD_W+1:0] t;
      for (int i = 0; i < 6; i++) begin
         t = {{2{coord_ff[i][COORD_W-1]}}, coord_ff[i]} + {3'b000, half_ff[i % 3]};
         neg2_in[i] = t[COORD_W+1];
         mag_in[i]  = neg2_in[i] ? 32'(-t) : t[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            mag_ff[i]  <= mag_in[i];
            neg2_ff[i] <= neg2_in[i];
         end
      end
   end

   // ---------------- stage 3: scale by reciprocal cell size, keep integer part
   always_comb begin
      logic [63:0] prod;
      for (int i = 0; i < 6; i++) begin
         prod        = 64'(mag_ff[i]) * 64'(inv_ff[i % 3]);
         ipart_in[i] = prod[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 6; i++) begin
            ipart_ff[i] <= ipart_in[i];
            neg3_ff[i]  <= neg2_ff[i];
         end
      end
   end

   // ---------------- stage 4: clamp, interleave, shared level, index
   always_comb begin
      logic [31:0]        top;
      logic [CELL_W-1:0]  grid [6];
      logic [CODE_W-1:0]  lo_code, hi_code, diff;
      logic [LEVEL_W-1:0] up;
      logic               flag;
      top  = (32'd1 << div_level_ff) - 32'd1;
      flag = 1'b0;
      for (int i = 0; i < 6; i++) begin
         if (neg3_ff[i]) begin
            grid[i] = '0;
            if (ipart_ff[i] != 32'd0) flag = 1'b1;
         end else if (ipart_ff[i] > top) begin
            grid[i] = top[CELL_W-1:0];
            flag    = 1'b1;
         end else begin
            grid[i] = ipart_ff[i][CELL_W-1:0];
         end
      end
      lo_code = spread3(grid[0]) | (spread3(grid[1]) << 1) | (spread3(grid[2]) << 2);
      hi_code = spread3(grid[3]) | (spread3(grid[4]) << 1) | (spread3(grid[5]) << 2);
      diff    = lo_code ^ hi_code;
      up      = '0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
         if ((32'(l) < 32'(div_level_ff)) && (|diff[3*l +: 3])) begin
            up = LEVEL_W'(l + 1);
         end
      end
      level_in = div_level_ff - up;
      index_in = level_base(level_in) + INDEX_W'(lo_code >> (3 * up));
      flag_in  = flag;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         index_ff <= index_in;
         level_ff <= level_in;
         flag_ff  <= flag_in;
      end
   end

   assign rsp_bus.valid       = vo_ff;
   assign rsp_bus.cell_index  = index_ff;
   assign rsp_bus.cell_level  = level_ff;
   assign rsp_bus.out_of_area = flag_ff;

   // ---------------- checks
   a_level_in_range: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> (rsp_bus.cell_level <= div_level_ff))
      else $error("cell level deeper than configured levels");

   a_root_index: assert property (@(posedge clock) disable iff (reset)
      (vo_ff && (rsp_bus.cell_level == '0)) |-> (rsp_bus.cell_index == '0))
      else $error("level zero cell with nonzero index");

   a_index_floor: assert property (@(posedge clock) disable iff (reset)
      vo_ff |-> (rsp_bus.cell_index >= level_base(rsp_bus.cell_level)))
      else $error("cell index below its level base");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (vo_ff && !rsp_bus.ready) |-> !req_bus.ready)
      else $error("request taken while output word stalled");

endmodule
